>>> design/utf8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Types and constants shared by the decoder's front end, queue and back end.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CP_W      = 21;
    localparam int BYTE_W    = 8;
    localparam int NREP_W    = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [PADDR_W-1:0] REG_REPLACEMENT = 3'd0;
    localparam logic [CP_W-1:0]    REPL_RESET      = 21'h00FFFD;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    localparam logic [CP_W-1:0] MIN_LEN_2 = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN_3 = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN_4 = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

    localparam logic [NREP_W-1:0] MAX_RESULTS = 3'd4;

    // One request to the back end: a run of replacements, then an optional
    // well-formed code point.
    typedef struct packed {
        logic [NREP_W-1:0] nrep;
        logic              has_final;
        logic [CP_W-1:0]   cp;
        logic              string_end;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

>>> design/utf8d_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder channels
// Valid/ready channels for raw input bytes and for decoded code points.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       string_end;

    modport source (output valid, output byte_in, output string_end, input ready);
    modport sink (input valid, input byte_in, input string_end, output ready);
endinterface

interface utf8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        well_formed;
    logic        run_last;
    logic        string_done;

    modport source (output valid, output code_point, output well_formed,
                    output run_last, output string_done, input ready);
    modport sink (input valid, input code_point, input well_formed,
                  input run_last, input string_done, output ready);
endinterface

`default_nettype wire

>>> design/utf8d_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the pending sequence and classifies each byte into a
// request for the back end.
// ----------------------------------------------------------------------------
module utf8d_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    utf8d_byte_if.sink              in_bytes,
    input  wire utf8d_pkg::q_status_t q_status,
    output      logic               push,
    output      utf8d_pkg::job_t    job
);

    logic [utf8d_pkg::CP_W-1:0] partial_reg, partial_next;
    logic [2:0]                 len_reg, len_next;
    logic [1:0]                 held_reg, held_next;
    logic                       accept;

    assign in_bytes.ready = !q_status.full;
    assign accept         = in_bytes.valid && in_bytes.ready;

    always_comb
    begin
        logic [7:0]                 b;
        logic                       is_cont;
        logic [utf8d_pkg::CP_W-1:0] val;
        logic [utf8d_pkg::CP_W-1:0] minv;
        logic                       bad;
        logic                       f_rep;
        logic                       f_final;
        logic                       f_start;
        logic [2:0]                 f_len;
        logic [utf8d_pkg::CP_W-1:0] f_val;

        b       = in_bytes.byte_in;
        is_cont = (b[7:6] == 2'b10);
        val     = {partial_reg[14:0], b[5:0]};

        f_rep   = 1'b0;
        f_final = 1'b0;
        f_start = 1'b0;
        f_len   = utf8d_pkg::LEN_NONE;
        f_val   = '0;
        priority if (b[7] == 1'b0)
        begin
            f_final = 1'b1;
        end
        else if (b[7:5] == 3'b110)
        begin
            f_len = utf8d_pkg::LEN_2;
            f_val = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            f_len = utf8d_pkg::LEN_3;
            f_val = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            f_len = utf8d_pkg::LEN_4;
            f_val = {18'd0, b[2:0]};
        end
        else
        begin
            f_rep = 1'b1;
        end
        if (f_len != utf8d_pkg::LEN_NONE)
        begin
            if (in_bytes.string_end)
            begin
                f_rep = 1'b1;
            end
            else
            begin
                f_start = 1'b1;
            end
        end

        unique case (len_reg)
            utf8d_pkg::LEN_2: minv = utf8d_pkg::MIN_LEN_2;
            utf8d_pkg::LEN_3: minv = utf8d_pkg::MIN_LEN_3;
            default:          minv = utf8d_pkg::MIN_LEN_4;
        endcase
        bad = (val < minv) || ((val >= utf8d_pkg::SURR_LO) && (val <= utf8d_pkg::SURR_HI))
              || (val > utf8d_pkg::CP_MAX);

        job.nrep       = '0;
        job.has_final  = 1'b0;
        job.cp         = {13'd0, b};
        job.string_end = in_bytes.string_end;
        partial_next   = partial_reg;
        len_next       = len_reg;
        held_next      = held_reg;

        if (len_reg == utf8d_pkg::LEN_NONE)
        begin
            job.nrep      = {2'd0, f_rep};
            job.has_final = f_final;
            if (f_start)
            begin
                len_next     = f_len;
                partial_next = f_val;
                held_next    = 2'd0;
            end
        end
        else if (is_cont)
        begin
            if (({1'b0, held_reg} + 3'd2) >= len_reg)
            begin
                if (bad)
                begin
                    job.nrep = 3'd2 + {1'b0, held_reg};
                end
                else
                begin
                    job.has_final = 1'b1;
                    job.cp        = val;
                end
                len_next     = utf8d_pkg::LEN_NONE;
                partial_next = '0;
                held_next    = 2'd0;
            end
            else if (in_bytes.string_end)
            begin
                job.nrep     = 3'd2 + {1'b0, held_reg};
                len_next     = utf8d_pkg::LEN_NONE;
                partial_next = '0;
                held_next    = 2'd0;
            end
            else
            begin
                partial_next = val;
                held_next    = held_reg + 2'd1;
            end
        end
        else
        begin
            job.nrep      = 3'd1 + {1'b0, held_reg} + {2'd0, f_rep};
            job.has_final = f_final;
            len_next      = f_start ? f_len : utf8d_pkg::LEN_NONE;
            partial_next  = f_start ? f_val : '0;
            held_next     = 2'd0;
        end
    end

    assign push = accept && ((job.nrep != '0) || job.has_final);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            len_reg     <= utf8d_pkg::LEN_NONE;
            held_reg    <= 2'd0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            len_reg     <= len_next;
            held_reg    <= held_next;
        end
    end

    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg == utf8d_pkg::LEN_NONE || len_reg == utf8d_pkg::LEN_2
        || len_reg == utf8d_pkg::LEN_3 || len_reg == utf8d_pkg::LEN_4)
        else $error("front: illegal sequence length");
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg == utf8d_pkg::LEN_NONE |-> held_reg == 2'd0 && partial_reg == '0)
        else $error("front: stale bytes with no sequence pending");
    a_held_short: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg != utf8d_pkg::LEN_NONE |-> ({1'b0, held_reg} + 3'd2) < len_reg + 3'd1)
        else $error("front: sequence holds too many bytes");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_bytes.string_end |=> len_reg == utf8d_pkg::LEN_NONE)
        else $error("front: sequence left pending after string end");
    a_job_size: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> job.nrep + {2'd0, job.has_final} <= utf8d_pkg::MAX_RESULTS)
        else $error("front: too many results for one byte");

endmodule

`default_nettype wire

>>> design/utf8d_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder request queue
// Small first-in first-out buffer of requests between front and back end.
// ----------------------------------------------------------------------------
module utf8d_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire utf8d_pkg::job_t      push_job,
    input  wire logic                 pop,
    output      utf8d_pkg::job_t      head_job,
    output      utf8d_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    utf8d_pkg::job_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue: push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue: pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue: count out of range");

endmodule

`default_nettype wire

>>> design/utf8d_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Expands each request into its results and drives the output register.
// ----------------------------------------------------------------------------
module utf8d_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [utf8d_pkg::CP_W-1:0] replacement,
    input  wire utf8d_pkg::job_t            head_job,
    input  wire utf8d_pkg::q_status_t       q_status,
    output      logic                       pop,
    utf8d_cp_if.source                      out_points
);

    logic                         cur_valid_reg, cur_valid_next;
    utf8d_pkg::job_t              cur_reg, cur_next;
    logic                         out_valid_reg, out_valid_next;
    logic [utf8d_pkg::CP_W-1:0]   out_cp_reg;
    logic                         out_ok_reg;
    logic                         out_last_reg;
    logic                         out_done_reg;

    logic                         load;
    logic                         item_last;
    logic                         item_ok;
    logic [utf8d_pkg::CP_W-1:0]   item_cp;

    assign load = cur_valid_reg && (!out_valid_reg || out_points.ready);

    always_comb
    begin
        if (cur_reg.nrep != '0)
        begin
            item_cp   = replacement;
            item_ok   = 1'b0;
            item_last = (cur_reg.nrep == 3'd1) && !cur_reg.has_final;
        end
        else
        begin
            item_cp   = cur_reg.cp;
            item_ok   = 1'b1;
            item_last = 1'b1;
        end
    end

    assign pop = !q_status.empty && (!cur_valid_reg || (load && item_last));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (pop)
        begin
            cur_next       = head_job;
            cur_valid_next = 1'b1;
        end
        else if (load)
        begin
            cur_valid_next = !item_last;
            if (cur_reg.nrep != '0)
            begin
                cur_next.nrep = cur_reg.nrep - 3'd1;
            end
        end
        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_points.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (load)
        begin
            out_cp_reg   <= item_cp;
            out_ok_reg   <= item_ok;
            out_last_reg <= item_last;
            out_done_reg <= item_last && cur_reg.string_end;
        end
    end

    assign out_points.valid       = out_valid_reg;
    assign out_points.code_point  = out_cp_reg;
    assign out_points.well_formed = out_ok_reg;
    assign out_points.run_last    = out_last_reg;
    assign out_points.string_done = out_done_reg;

    a_live_job: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && cur_reg.nrep == '0 |-> cur_reg.has_final)
        else $error("back: request with no result left");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_last_reg)
        else $error("back: string done without run last");
    a_clean_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ok_reg |-> out_last_reg)
        else $error("back: clean code point not last of its run");
    a_nrep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> cur_reg.nrep <= utf8d_pkg::MAX_RESULTS)
        else $error("back: replacement count out of range");

endmodule

`default_nettype wire

>>> design/utf8_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream into code points, substituting a programmable
// replacement value for every malformed byte.
// ----------------------------------------------------------------------------
// A byte's first result goes through the request queue and the current-request
// register into the output register. Throughput: one byte per cycle while each
// byte gives at most one result and the output is not stalled. The results of a
// byte form bursts the request queue absorbs; input stalls only on a full queue.
// Reset clears the pending sequence, the queue and the output register, and sets
// the replacement register to 0xFFFD.
module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    utf8d_byte_if.sink                         in_bytes,
    utf8d_cp_if.source                         out_points,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [utf8d_pkg::PADDR_W-1:0] paddr,
    input  wire logic [utf8d_pkg::PDATA_W-1:0] pwdata,
    output      logic [utf8d_pkg::PDATA_W-1:0] prdata,
    output      logic                          pready
);

    logic [utf8d_pkg::CP_W-1:0] repl_reg;
    utf8d_pkg::job_t            push_job;
    utf8d_pkg::job_t            head_job;
    utf8d_pkg::q_status_t       q_status;
    logic                       push;
    logic                       pop;

    assign pready = 1'b1;
    assign prdata = {{(utf8d_pkg::PDATA_W - utf8d_pkg::CP_W){1'b0}}, repl_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg <= utf8d_pkg::REPL_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2:2] == utf8d_pkg::REG_REPLACEMENT[2:2])
        begin
            repl_reg <= pwdata[utf8d_pkg::CP_W-1:0];
        end
    end

    utf8d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_bytes (in_bytes),
        .q_status (q_status),
        .push     (push),
        .job      (push_job)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    utf8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .replacement (repl_reg),
        .head_job    (head_job),
        .q_status    (q_status),
        .pop         (pop),
        .out_points  (out_points)
    );

endmodule

`default_nettype wire

>>> sim/tb_utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives byte requests into the decoder, predicts every code point with a
// behavioral decoder kept in step with the accepted bytes, and compares each
// accepted result field by field. Directed strings cover the edge cases,
// then random strings of mostly well-formed characters with broken ones mixed
// in run under several replacement values and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;

    typedef struct packed {
        logic [utf8d_pkg::CP_W-1:0] cp;
        logic                       ok;
        logic                       run_last;
        logic                       done;
    } point_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [utf8d_pkg::PADDR_W-1:0] paddr;
    logic [utf8d_pkg::PDATA_W-1:0] pwdata;
    logic [utf8d_pkg::PDATA_W-1:0] prdata;
    logic                          pready;

    utf8d_byte_if byte_ch ();
    utf8d_cp_if   point_ch ();

    utf8_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_bytes   (byte_ch),
        .out_points (point_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    point_t                     expected_points[$];
    logic [7:0]                 pending_bytes[$];
    logic [utf8d_pkg::CP_W-1:0] repl_value;
    logic [utf8d_pkg::CP_W-1:0] acc_value;
    logic [2:0]                 seq_len;
    logic [1:0]                 held;
    int                         mismatches;
    int                         idle_pct;
    int                         stall_pct;

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    function automatic void push_point(logic [utf8d_pkg::CP_W-1:0] cp, logic ok);
        point_t p;
        p.cp       = cp;
        p.ok       = ok;
        p.run_last = 1'b0;
        p.done     = 1'b0;
        expected_points.push_back(p);
    endfunction

    function automatic void abandon_sequence();
        push_point(repl_value, 1'b0);
        for (int k = 0; k < int'(held); k++)
            push_point(repl_value, 1'b0);
        acc_value = '0;
        seq_len   = utf8d_pkg::LEN_NONE;
        held      = '0;
    endfunction

    function automatic void decode_lead(logic [7:0] b, logic last);
        logic [2:0]                 len;
        logic [utf8d_pkg::CP_W-1:0] val;
        len = utf8d_pkg::LEN_NONE;
        val = '0;
        if (!b[7])
            push_point({13'd0, b}, 1'b1);
        else
        begin
            if (b[7:5] == 3'b110)
            begin
                len = utf8d_pkg::LEN_2;
                val = {16'd0, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                len = utf8d_pkg::LEN_3;
                val = {17'd0, b[3:0]};
            end
            else if (b[7:3] == 5'b11110)
            begin
                len = utf8d_pkg::LEN_4;
                val = {18'd0, b[2:0]};
            end
            if (len == utf8d_pkg::LEN_NONE || last)
                push_point(repl_value, 1'b0);
            else
            begin
                seq_len   = len;
                acc_value = val;
                held      = '0;
            end
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        int                         first;
        point_t                     tail;
        logic [utf8d_pkg::CP_W-1:0] val;
        logic [utf8d_pkg::CP_W-1:0] floor_value;
        logic                       bad;
        first = expected_points.size();
        if (seq_len == utf8d_pkg::LEN_NONE)
            decode_lead(b, last);
        else if (b[7:6] != 2'b10)
        begin
            abandon_sequence();
            decode_lead(b, last);
        end
        else
        begin
            val = {acc_value[14:0], b[5:0]};
            if (int'(held) + 2 >= int'(seq_len))
            begin
                floor_value = (seq_len == utf8d_pkg::LEN_2) ? utf8d_pkg::MIN_LEN_2 :
                              (seq_len == utf8d_pkg::LEN_3) ? utf8d_pkg::MIN_LEN_3 :
                                                              utf8d_pkg::MIN_LEN_4;
                bad = (val < floor_value)
                      || (val >= utf8d_pkg::SURR_LO && val <= utf8d_pkg::SURR_HI)
                      || (val > utf8d_pkg::CP_MAX);
                if (bad)
                begin
                    abandon_sequence();
                    push_point(repl_value, 1'b0);
                end
                else
                begin
                    push_point(val, 1'b1);
                    acc_value = '0;
                    seq_len   = utf8d_pkg::LEN_NONE;
                    held      = '0;
                end
            end
            else if (last)
            begin
                abandon_sequence();
                decode_lead(b, last);
            end
            else
            begin
                acc_value = val;
                held      = held + 2'd1;
            end
        end
        if (expected_points.size() > first)
        begin
            tail          = expected_points[expected_points.size() - 1];
            tail.run_last = 1'b1;
            tail.done     = last;
            expected_points[expected_points.size() - 1] = tail;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        point_t want;
        if (rst_n === 1'b1)
        begin
            if (point_ch.valid && point_ch.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result: code_point %h", point_ch.code_point);
                    mismatches++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (point_ch.code_point !== want.cp)
                    begin
                        $error("code_point: expected %h, got %h", want.cp,
                               point_ch.code_point);
                        mismatches++;
                    end
                    if (point_ch.well_formed !== want.ok)
                    begin
                        $error("well_formed: expected %b, got %b", want.ok,
                               point_ch.well_formed);
                        mismatches++;
                    end
                    if (point_ch.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %b, got %b", want.run_last,
                               point_ch.run_last);
                        mismatches++;
                    end
                    if (point_ch.string_done !== want.done)
                    begin
                        $error("string_done: expected %b, got %b", want.done,
                               point_ch.string_done);
                        mismatches++;
                    end
                end
            end
            if (byte_ch.valid && byte_ch.ready)
                predict_byte(byte_ch.byte_in, byte_ch.string_end);
        end
    end

    always @(posedge clk)
        point_ch.ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.byte_in    <= b;
        byte_ch.string_end <= last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
    endtask

    task automatic send_pending();
        for (int i = 0; i < pending_bytes.size(); i++)
            send_byte(pending_bytes[i], i == pending_bytes.size() - 1);
        pending_bytes.delete();
    endtask

    task automatic drain();
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_replacement(logic [utf8d_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= utf8d_pkg::REG_REPLACEMENT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        repl_value = value[utf8d_pkg::CP_W-1:0];
        @(posedge clk);
    endtask

    task automatic check_replacement();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= utf8d_pkg::REG_REPLACEMENT;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {{(utf8d_pkg::PDATA_W - utf8d_pkg::CP_W){1'b0}}, repl_value})
        begin
            $error("replacement_code: expected %h, got %h", repl_value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void push_encoded(logic [utf8d_pkg::CP_W-1:0] cp, int len,
                                         int keep);
        logic [7:0] enc[4];
        unique case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            pending_bytes.push_back(enc[i]);
    endfunction

    function automatic logic [utf8d_pkg::CP_W-1:0] random_scalar(int len);
        logic [utf8d_pkg::CP_W-1:0] cp;
        unique case (len)
            1: cp = utf8d_pkg::CP_W'($urandom_range(0, 'h7F));
            2: cp = utf8d_pkg::CP_W'($urandom_range('h80, 'h7FF));
            3:
            begin
                cp = utf8d_pkg::CP_W'($urandom_range('h800, 'hFFFF));
                if (cp >= utf8d_pkg::SURR_LO && cp <= utf8d_pkg::SURR_HI)
                    cp = cp ^ 21'h002000;
            end
            default: cp = utf8d_pkg::CP_W'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    function automatic void append_random_char();
        int kind;
        int len;
        kind = $urandom_range(99);
        len  = $urandom_range(2, 4);
        if (kind < 55)
        begin
            len = $urandom_range(1, 4);
            push_encoded(random_scalar(len), len, len);
        end
        else if (kind < 65)
            push_encoded(random_scalar(len), len, $urandom_range(1, len - 1));
        else if (kind < 72)
            push_encoded(utf8d_pkg::CP_W'($urandom_range(0, (len == 2) ? 'h7F :
                                                            (len == 3) ? 'h7FF : 'hFFFF)),
                         len, len);
        else if (kind < 78)
            push_encoded(utf8d_pkg::CP_W'($urandom_range('hD800, 'hDFFF)), 3, 3);
        else if (kind < 84)
            push_encoded(utf8d_pkg::CP_W'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
        else
            pending_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic test_register_access();
        check_replacement();
    endtask

    task automatic test_directed_cases();
        idle_pct  = 0;
        stall_pct = 0;
        pending_bytes = '{8'h00, 8'h7F};
        send_pending();
        pending_bytes = '{8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_pending();
        pending_bytes = '{8'h80, 8'hFF, 8'hF8, 8'hC0, 8'h80};
        send_pending();
        pending_bytes = '{8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80};
        send_pending();
        pending_bytes = '{8'hE2, 8'h82, 8'h41};
        send_pending();
        pending_bytes = '{8'hF0, 8'h90, 8'h80};
        send_pending();
        pending_bytes = '{8'hC3};
        send_pending();
        byte_ch.valid <= 1'b0;
    endtask

    task automatic test_random_traffic(int idle, int stall,
                                       logic [utf8d_pkg::PDATA_W-1:0] repl, int budget);
        int sent;
        drain();
        write_replacement(repl);
        check_replacement();
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < budget)
        begin
            repeat ($urandom_range(1, 8)) append_random_char();
            sent += pending_bytes.size();
            send_pending();
        end
        byte_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.byte_in    = '0;
        byte_ch.string_end = 1'b0;
        point_ch.ready     = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        repl_value         = utf8d_pkg::REPL_RESET;
        acc_value          = '0;
        seq_len            = utf8d_pkg::LEN_NONE;
        held               = '0;
        mismatches         = 0;
        idle_pct           = 0;
        stall_pct          = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_directed_cases();
        test_random_traffic(0, 0, 32'h0000_0000, 60);
        test_random_traffic(76, 0, 32'h0010_FFFF, 60);
        test_random_traffic(0, 76, 32'hFFFF_FFFF, 60);
        test_random_traffic(30, 30, $urandom, 60);
        drain();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
design/utf8d_pkg.sv
design/utf8d_if.sv
design/utf8d_front.sv
design/utf8d_queue.sv
design/utf8d_back.sv
design/utf8_stream_decoder.sv
sim/tb_utf8_stream_decoder.sv
